>>> rtl/core/rgbhsv_pkg.sv
// Shared types and default constants for the RGB to HSV pixel converter.
package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 16;

    // Control that travels with each item down the divider chain.
    typedef struct packed {
        logic valid;
        logic sat_zero;
        logic hue_zero;
    } t_ctl;

endpackage

>>> rtl/core/rgbhsv_front.sv
// Front stage: finds value, chroma and the hue sector numerator, then registers them.
module rgbhsv_front #(
    parameter int CHANNEL_BITS = 8,
    parameter int REM_BITS     = CHANNEL_BITS + 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output rgbhsv_pkg::t_ctl        o_ctl,
    output logic [REM_BITS-1:0]     o_sat_rem,
    output logic [CHANNEL_BITS-1:0] o_sat_div,
    output logic [REM_BITS-1:0]     o_hue_rem,
    output logic [REM_BITS-1:0]     o_hue_div
);
    import rgbhsv_pkg::*;

    logic [CHANNEL_BITS-1:0] w_max;
    logic [CHANNEL_BITS-1:0] w_min;
    logic [REM_BITS-1:0]     w_r;
    logic [REM_BITS-1:0]     w_g;
    logic [REM_BITS-1:0]     w_b;
    logic [REM_BITS-1:0]     w_c;
    logic [REM_BITS-1:0]     w_c6;
    logic [REM_BITS-1:0]     w_num;
    logic                    w_neg;

    t_ctl                    r_ctl,     n_ctl;
    logic [REM_BITS-1:0]     r_sat_rem, n_sat_rem;
    logic [CHANNEL_BITS-1:0] r_sat_div, n_sat_div;
    logic [REM_BITS-1:0]     r_hue_rem, n_hue_rem;
    logic [REM_BITS-1:0]     r_hue_div, n_hue_div;

    always_comb begin
        w_max = (i_red > i_green) ? i_red : i_green;
        if (i_blue > w_max) begin
            w_max = i_blue;
        end
        w_min = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_min) begin
            w_min = i_blue;
        end
        w_r  = REM_BITS'(i_red);
        w_g  = REM_BITS'(i_green);
        w_b  = REM_BITS'(i_blue);
        w_c  = REM_BITS'(w_max - w_min);
        w_c6 = (w_c << 2) + (w_c << 1);
        w_neg = 1'b0;
        // Ties for the maximum go to red, then to green.
        if (w_max == i_red) begin
            w_num = w_g - w_b;
            w_neg = (i_green < i_blue);
        end else if (w_max == i_green) begin
            w_num = w_b - w_r + (w_c << 1);
        end else begin
            w_num = w_r - w_g + (w_c << 2);
        end
        // A negative numerator is moved up by one full turn; the wrap drops it again.
        n_hue_rem = w_neg ? (w_num + w_c6) : w_num;
        n_hue_div = w_c6;
        n_sat_rem = w_c;
        n_sat_div = w_max;
        n_ctl.valid    = i_take;
        n_ctl.sat_zero = (w_max == '0);
        n_ctl.hue_zero = (w_c == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_sat_rem <= n_sat_rem;
        r_sat_div <= n_sat_div;
        r_hue_rem <= n_hue_rem;
        r_hue_div <= n_hue_div;
    end

    assign o_ctl     = r_ctl;
    assign o_sat_rem = r_sat_rem;
    assign o_sat_div = r_sat_div;
    assign o_hue_rem = r_hue_rem;
    assign o_hue_div = r_hue_div;

endmodule

>>> rtl/core/rgbhsv_cell.sv
// One divider cell: yields one quotient bit of saturation and of hue per item.
module rgbhsv_cell #(
    parameter int CHANNEL_BITS = 8,
    parameter int REM_BITS     = CHANNEL_BITS + 4,
    parameter int QUOT_BITS    = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rgbhsv_pkg::t_ctl        i_ctl,
    input  logic [REM_BITS-1:0]     i_sat_rem,
    input  logic [CHANNEL_BITS-1:0] i_sat_div,
    input  logic [QUOT_BITS-1:0]    i_sat_quot,
    input  logic [REM_BITS-1:0]     i_hue_rem,
    input  logic [REM_BITS-1:0]     i_hue_div,
    input  logic [QUOT_BITS-1:0]    i_hue_quot,
    output rgbhsv_pkg::t_ctl        o_ctl,
    output logic [REM_BITS-1:0]     o_sat_rem,
    output logic [CHANNEL_BITS-1:0] o_sat_div,
    output logic [QUOT_BITS-1:0]    o_sat_quot,
    output logic [REM_BITS-1:0]     o_hue_rem,
    output logic [REM_BITS-1:0]     o_hue_div,
    output logic [QUOT_BITS-1:0]    o_hue_quot
);
    import rgbhsv_pkg::*;

    logic [REM_BITS-1:0]     w_sat_div;
    logic                    w_sat_ge;
    logic [REM_BITS-1:0]     w_sat_diff;
    logic                    w_hue_ge;
    logic [REM_BITS-1:0]     w_hue_diff;

    t_ctl                    r_ctl,      n_ctl;
    logic [REM_BITS-1:0]     r_sat_rem,  n_sat_rem;
    logic [CHANNEL_BITS-1:0] r_sat_div,  n_sat_div;
    logic [QUOT_BITS-1:0]    r_sat_quot, n_sat_quot;
    logic [REM_BITS-1:0]     r_hue_rem,  n_hue_rem;
    logic [REM_BITS-1:0]     r_hue_div,  n_hue_div;
    logic [QUOT_BITS-1:0]    r_hue_quot, n_hue_quot;

    // Restoring step: compare, subtract when it fits, then double the remainder.
    always_comb begin
        w_sat_div  = REM_BITS'(i_sat_div);
        w_sat_ge   = (i_sat_rem >= w_sat_div);
        w_sat_diff = w_sat_ge ? (i_sat_rem - w_sat_div) : i_sat_rem;
        w_hue_ge   = (i_hue_rem >= i_hue_div);
        w_hue_diff = w_hue_ge ? (i_hue_rem - i_hue_div) : i_hue_rem;
        n_sat_rem  = w_sat_diff << 1;
        n_hue_rem  = w_hue_diff << 1;
        n_sat_quot = {i_sat_quot[QUOT_BITS-2:0], w_sat_ge};
        n_hue_quot = {i_hue_quot[QUOT_BITS-2:0], w_hue_ge};
        n_sat_div  = i_sat_div;
        n_hue_div  = i_hue_div;
        n_ctl      = i_ctl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_sat_rem  <= n_sat_rem;
        r_sat_div  <= n_sat_div;
        r_sat_quot <= n_sat_quot;
        r_hue_rem  <= n_hue_rem;
        r_hue_div  <= n_hue_div;
        r_hue_quot <= n_hue_quot;
    end

    assign o_ctl      = r_ctl;
    assign o_sat_rem  = r_sat_rem;
    assign o_sat_div  = r_sat_div;
    assign o_sat_quot = r_sat_quot;
    assign o_hue_rem  = r_hue_rem;
    assign o_hue_div  = r_hue_div;
    assign o_hue_quot = r_hue_quot;

endmodule

>>> rtl/core/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter: front stage and a chain of divider cells.
//
// Usage: drive i_red, i_green and i_blue and raise start for one cycle per item.
// busy is held low, so an item is taken at every rising edge with start high,
// one pixel per clock, back to back without gaps.
// Each item passes through the front stage, which finds value, chroma and the
// hue numerator, and then through each of the FRACTION_BITS + 1 divider cells,
// each of which produces one quotient bit of saturation and one of hue.
// That chain length sets the latency; the rate is one item per cycle since
// every cell works on a different item.
// The result shows on o_hue, o_saturation and o_brightness for exactly one
// cycle, marked by o_valid. The receiver cannot hold it off and must take it
// in that cycle. Synchronous reset clears the valid flags along the chain,
// so no result appears until new items come in; the data path is not reset.
module rgb_to_hsv_pixel #(
    parameter int CHANNEL_BITS  = rgbhsv_pkg::CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = rgbhsv_pkg::FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CHANNEL_BITS-1:0]  i_red,
    input  logic [CHANNEL_BITS-1:0]  i_green,
    input  logic [CHANNEL_BITS-1:0]  i_blue,
    output logic                     o_valid,
    output logic [FRACTION_BITS-1:0] o_hue,
    output logic [FRACTION_BITS:0]   o_saturation,
    output logic [CHANNEL_BITS-1:0]  o_brightness
);
    import rgbhsv_pkg::*;

    // Remainders hold up to twice six times the chroma.
    localparam int REM_BITS  = CHANNEL_BITS + 4;
    localparam int QUOT_BITS = FRACTION_BITS + 1;
    localparam int NUM_CELLS = FRACTION_BITS + 1;

    t_ctl                    w_ctl      [0:NUM_CELLS];
    logic [REM_BITS-1:0]     w_sat_rem  [0:NUM_CELLS];
    logic [CHANNEL_BITS-1:0] w_sat_div  [0:NUM_CELLS];
    logic [QUOT_BITS-1:0]    w_sat_quot [0:NUM_CELLS];
    logic [REM_BITS-1:0]     w_hue_rem  [0:NUM_CELLS];
    logic [REM_BITS-1:0]     w_hue_div  [0:NUM_CELLS];
    logic [QUOT_BITS-1:0]    w_hue_quot [0:NUM_CELLS];

    // The pipeline never stalls, so every start is taken.
    assign busy = 1'b0;

    rgbhsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .REM_BITS     (REM_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (start && !busy),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_ctl     (w_ctl[0]),
        .o_sat_rem (w_sat_rem[0]),
        .o_sat_div (w_sat_div[0]),
        .o_hue_rem (w_hue_rem[0]),
        .o_hue_div (w_hue_div[0])
    );

    // Quotients start empty; each cell shifts in one bit.
    assign w_sat_quot[0] = '0;
    assign w_hue_quot[0] = '0;

    // The first cell gives the integer bit: it is set for saturation only at
    // full saturation and is clear for hue whenever the chroma is nonzero,
    // since the hue numerator then stays below its divisor.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rgbhsv_cell #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .REM_BITS     (REM_BITS),
            .QUOT_BITS    (QUOT_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[k]),
            .i_sat_rem  (w_sat_rem[k]),
            .i_sat_div  (w_sat_div[k]),
            .i_sat_quot (w_sat_quot[k]),
            .i_hue_rem  (w_hue_rem[k]),
            .i_hue_div  (w_hue_div[k]),
            .i_hue_quot (w_hue_quot[k]),
            .o_ctl      (w_ctl[k+1]),
            .o_sat_rem  (w_sat_rem[k+1]),
            .o_sat_div  (w_sat_div[k+1]),
            .o_sat_quot (w_sat_quot[k+1]),
            .o_hue_rem  (w_hue_rem[k+1]),
            .o_hue_div  (w_hue_div[k+1]),
            .o_hue_quot (w_hue_quot[k+1])
        );
    end

    // A black pixel divides by zero value and a grey one by zero chroma; the
    // flags carried from the front stage force those results to zero.
    assign o_valid      = w_ctl[NUM_CELLS].valid;
    assign o_hue        = w_ctl[NUM_CELLS].hue_zero ? '0
                                                    : w_hue_quot[NUM_CELLS][FRACTION_BITS-1:0];
    assign o_saturation = w_ctl[NUM_CELLS].sat_zero ? '0 : w_sat_quot[NUM_CELLS];
    assign o_brightness = w_sat_div[NUM_CELLS];

endmodule
